>>> sv/tepc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tepc_pkg;

    // channel format: unorm, all ones stands for 1.0
    localparam int CH_W   = 16;
    localparam int ACC_W  = CH_W + 6;
    localparam int PROD_W = ACC_W + CH_W;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CH_W-1:0] ONE     = {CH_W{1'b1}};
    localparam logic [CH_W-1:0] HALF_M1 = {1'b0, {(CH_W-1){1'b1}}};

    localparam logic [2:0] MODE_ADD      = 3'd0;
    localparam logic [2:0] MODE_MAX      = 3'd1;
    localparam logic [2:0] MODE_MIN      = 3'd2;
    localparam logic [2:0] MODE_OVER_TOP = 3'd3;
    localparam logic [2:0] MODE_OVER_BOT = 3'd4;

    // premultiplied sample: ch[0..2] rgb, ch[3] alpha
    typedef struct packed {
        logic                 last;
        logic [3:0][CH_W-1:0] ch;
    } t_sample;

    // floor(u / ONE) via folding: 2^CH_W == 1 modulo ONE
    function automatic logic [ACC_W-1:0] div_one(input logic [PROD_W-1:0] u);
        logic [ACC_W-1:0]     h;
        logic [CH_W-1:0]      l;
        logic [ACC_W:0]       m;
        logic [ACC_W-CH_W:0]  h2;
        logic [CH_W-1:0]      l2;
        logic [CH_W:0]        m2;
        logic [ACC_W:0]       q;
        h  = u[PROD_W-1:CH_W];
        l  = u[CH_W-1:0];
        m  = {1'b0, h} + {{(ACC_W+1-CH_W){1'b0}}, l};
        h2 = m[ACC_W:CH_W];
        l2 = m[CH_W-1:0];
        m2 = {{(CH_W-(ACC_W-CH_W)){1'b0}}, h2} + {1'b0, l2};
        q  = {1'b0, h} + {{CH_W{1'b0}}, h2}
           + {{ACC_W{1'b0}}, (m2 >= {1'b0, ONE})};
        return q[ACC_W-1:0];
    endfunction

    // round half up of p / ONE
    function automatic logic [ACC_W-1:0] round_prod(input logic [PROD_W-1:0] p);
        return div_one(p + {{(PROD_W-CH_W){1'b0}}, HALF_M1});
    endfunction

    function automatic logic [CH_W-1:0] sat_one(input logic [ACC_W:0] x);
        return (x > {{(ACC_W+1-CH_W){1'b0}}, ONE}) ? ONE : x[CH_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/tepc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tepc_front
    import tepc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    input  wire logic [CH_W-1:0] i_alpha,
    input  wire logic [CH_W-1:0] i_opacity,
    input  wire logic            i_last_sample,
    output logic                 o_q_push,
    output t_sample              o_q_data,
    input  wire logic            i_q_full
);

    logic                   r_v1, r_v2, r_v3;
    logic [2*CH_W-1:0]      r_pa;
    logic [2:0][CH_W-1:0]   r_c1, r_c2;
    logic                   r_l1, r_l2, r_l3;
    logic [CH_W-1:0]        r_a2, r_a3;
    logic [2:0][2*CH_W-1:0] r_pc;
    logic                   en;
    logic [ACC_W-1:0]       a_rnd;
    logic [ACC_W-1:0]       s_rnd [3];

    // whole pipe holds when the tail beat cannot enter the queue
    assign en     = !(r_v3 && i_q_full);
    assign o_full = !en;

    assign a_rnd = round_prod({{(PROD_W-2*CH_W){1'b0}}, r_pa});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: alpha times opacity
            r_pa    <= {{CH_W{1'b0}}, i_alpha} * {{CH_W{1'b0}}, i_opacity};
            r_c1[0] <= i_red;
            r_c1[1] <= i_green;
            r_c1[2] <= i_blue;
            r_l1    <= i_last_sample;
            // stage 2: rounded alpha
            r_a2    <= a_rnd[CH_W-1:0];
            r_c2    <= r_c1;
            r_l2    <= r_l1;
            // stage 3: color times alpha
            for (int k = 0; k < 3; k++) begin
                r_pc[k] <= {{CH_W{1'b0}}, r_c2[k]} * {{CH_W{1'b0}}, r_a2};
            end
            r_a3    <= r_a2;
            r_l3    <= r_l2;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_rnd[k]       = round_prod({{(PROD_W-2*CH_W){1'b0}}, r_pc[k]});
            o_q_data.ch[k] = s_rnd[k][CH_W-1:0];
        end
        o_q_data.ch[3] = r_a3;
        o_q_data.last  = r_l3;
    end

    assign o_q_push = r_v3 && !i_q_full;

endmodule
`default_nettype wire

>>> sv/tepc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tepc_queue
    import tepc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_sample i_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_sample      o_data,
    output logic         o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_sample         r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/tepc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tepc_back
    import tepc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [2:0]      i_mode,
    input  wire logic            i_q_empty,
    input  wire t_sample         i_q_data,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [CH_W-1:0]      o_red,
    output logic [CH_W-1:0]      o_green,
    output logic [CH_W-1:0]      o_blue,
    output logic [CH_W-1:0]      o_alpha
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int NW  = 2 * CH_W + 2;
    localparam int CNW = $clog2(CH_W);

    logic [2:0]            r_state, n_state;
    logic [ACC_W-1:0]      r_acc [4];
    logic [ACC_W-1:0]      n_acc [4];
    logic                  r_run;
    logic [PROD_W-1:0]     r_p [4];
    t_sample               r_s;
    logic [2:0]            r_mode;
    logic [CH_W:0]         r_rem [3];
    logic [CH_W-1:0]       r_quo [3];
    logic [2:0]            r_sat;
    logic                  r_zero;
    logic [CH_W-1:0]       r_alpha_o;
    logic [CNW-1:0]        r_cnt;
    logic                  r_out_v;
    logic [3:0][CH_W-1:0]  r_out;

    logic [ACC_W-1:0]      acc_eff [4];
    logic [ACC_W-1:0]      mop [4];
    logic [CH_W-1:0]       f;
    logic                  mode_bot;
    logic [ACC_W-1:0]      s_ext [4];
    logic [ACC_W-1:0]      rp [4];
    logic [ACC_W:0]        sum [4];
    logic [CH_W-1:0]       c [4];
    logic [NW-1:0]         num [3];
    logic [CH_W:0]         dvs;
    logic [CH_W+1:0]       rem2 [3];
    logic [2:0]            ge;
    logic                  out_load;

    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign out_load = (r_state == ST_OUT) && (!r_out_v || i_pop);
    assign mode_bot = (i_mode == MODE_OVER_BOT);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc_eff[k] = r_run ? r_acc[k] : '0;
        end
        // over weight: one minus the alpha that lies on top
        f = mode_bot ? ONE - sat_one({1'b0, acc_eff[3]}) : ONE - i_q_data.ch[3];
        for (int k = 0; k < 4; k++) begin
            mop[k] = mode_bot ? {{(ACC_W-CH_W){1'b0}}, i_q_data.ch[k]} : acc_eff[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            s_ext[k] = {{(ACC_W-CH_W){1'b0}}, r_s.ch[k]};
            rp[k]    = round_prod(r_p[k]);
            sum[k]   = '0;
            unique case (r_mode)
                MODE_ADD: begin
                    sum[k]   = {1'b0, acc_eff[k]} + {1'b0, s_ext[k]};
                    n_acc[k] = sum[k][ACC_W] ? {ACC_W{1'b1}} : sum[k][ACC_W-1:0];
                end
                MODE_MAX: begin
                    n_acc[k] = (!r_run || s_ext[k] > r_acc[k]) ? s_ext[k] : r_acc[k];
                end
                MODE_MIN: begin
                    n_acc[k] = (!r_run || s_ext[k] < r_acc[k]) ? s_ext[k] : r_acc[k];
                end
                MODE_OVER_BOT: begin
                    sum[k]   = {1'b0, acc_eff[k]} + {1'b0, rp[k]};
                    n_acc[k] = {{(ACC_W-CH_W){1'b0}}, sat_one(sum[k])};
                end
                default: begin
                    // over new on top, and the unused codes
                    sum[k]   = {1'b0, s_ext[k]} + {1'b0, rp[k]};
                    n_acc[k] = {{(ACC_W-CH_W){1'b0}}, sat_one(sum[k])};
                end
            endcase
        end
    end

    // unpremultiply setup: numerator 2*c*ONE + a over divisor 2*a
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            c[k] = sat_one({1'b0, r_acc[k]});
        end
        for (int k = 0; k < 3; k++) begin
            num[k] = {1'b0, c[k], {(CH_W+1){1'b0}}} - {{(CH_W+1){1'b0}}, c[k], 1'b0}
                   + {{(CH_W+2){1'b0}}, c[3]};
        end
        dvs = {r_alpha_o, 1'b0};
        for (int k = 0; k < 3; k++) begin
            rem2[k] = {r_rem[k], r_quo[k][CH_W-1]};
            ge[k]   = rem2[k] >= {1'b0, dvs};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_ACC;
            ST_ACC:  n_state = r_s.last ? ST_PREP : ST_IDLE;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNW'(CH_W - 1)) n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_run   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC) begin
                r_run <= 1'b1;
            end else if (r_state == ST_PREP) begin
                r_run <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s    <= i_q_data;
            r_mode <= i_mode;
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= {{CH_W{1'b0}}, mop[k]} * {{ACC_W{1'b0}}, f};
            end
        end
        if (r_state == ST_ACC) begin
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= n_acc[k];
            end
        end
        if (r_state == ST_PREP) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= num[k][2*CH_W:CH_W];
                r_quo[k] <= num[k][CH_W-1:0];
                r_sat[k] <= (c[k] >= c[3]);
            end
            r_zero    <= (c[3] == '0);
            r_alpha_o <= c[3];
            r_cnt     <= '0;
        end
        if (r_state == ST_DIV) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= ge[k] ? (rem2[k][CH_W:0] - dvs) : rem2[k][CH_W:0];
                r_quo[k] <= {r_quo[k][CH_W-2:0], ge[k]};
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (out_load) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= r_zero ? '0 : (r_sat[k] ? ONE : r_quo[k]);
            end
            r_out[3] <= r_alpha_o;
        end
    end

    assign o_empty = !r_out_v;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
    assign o_alpha = r_out[3];

endmodule
`default_nettype wire

>>> sv/temporal_echo_pixel_compositor.sv
// path to empty going low: premultiply pipe, queue, accumulate, divider setup, divider, output load
// throughput: front takes one sample per cycle, while the queue has room, into a 3-stage
//   premultiply pipe and queue; the accumulate loop pops a sample and accumulates it
//   before the next; each run adds setup, a 16-step unpremultiply divider and output load
// reset: synchronous active low; clears pipe valids, queue pointers, run flag,
//   output valid and blend_mode, accumulator data needs none
`timescale 1ns / 1ps
`default_nettype none
module temporal_echo_pixel_compositor
    import tepc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // sample side
    input  wire logic            push,
    output logic                 full,
    input  wire logic [CH_W-1:0] i_red,
    input  wire logic [CH_W-1:0] i_green,
    input  wire logic [CH_W-1:0] i_blue,
    input  wire logic [CH_W-1:0] i_alpha,
    input  wire logic [CH_W-1:0] i_opacity,
    input  wire logic            i_last_sample,
    // pixel side
    output logic                 empty,
    input  wire logic            pop,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue,
    output logic [CH_W-1:0]      o_out_alpha,
    // blend mode register
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_wdata
);

    logic [2:0] r_blend_mode;
    logic       q_push, q_full, q_pop, q_empty;
    t_sample    q_wdata, q_rdata;

    // blend_mode: 0 add, 1 max, 2 min, 3 over new on top, 4 over new on bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= MODE_ADD;
        end else if (i_cfg_we) begin
            r_blend_mode <= i_cfg_wdata;
        end
    end

    // front: premultiply alpha by opacity, then color by alpha, rounded half up
    tepc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .i_opacity     (i_opacity),
        .i_last_sample (i_last_sample),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata),
        .i_q_full      (q_full)
    );

    // decoupling queue of premultiplied beats
    tepc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // back: accumulate per mode, unpremultiply on the last beat, hold the pixel
    tepc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_blend_mode),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_alpha   (o_out_alpha)
    );

endmodule
`default_nettype wire

>>> sv/tepc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tepc_checker
    import tepc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    input  wire logic            full,
    input  wire logic            i_last_sample,
    input  wire logic            empty,
    input  wire logic            pop,
    input  wire logic [CH_W-1:0] o_out_red,
    input  wire logic [CH_W-1:0] o_out_green,
    input  wire logic [CH_W-1:0] o_out_blue,
    input  wire logic [CH_W-1:0] o_out_alpha
);

    // runs ended at the input but not yet taken at the output
    logic [7:0] r_pend;
    logic       in_last, out_beat;

    assign in_last  = push && !full && i_last_sample;
    assign out_beat = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_last && !out_beat) begin
            r_pend <= r_pend + 1'b1;
        end else if (out_beat && !in_last) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> empty && !full)
        else $error("outputs not quiet after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_pend != 8'd0)
        else $error("pixel shown without a finished run");

    a_zero_alpha_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_alpha == '0 |->
            o_out_red == '0 && o_out_green == '0 && o_out_blue == '0)
        else $error("color nonzero on a fully transparent pixel");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_red) && $stable(o_out_green)
            && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("waiting pixel changed");

endmodule

bind temporal_echo_pixel_compositor tepc_checker u_tepc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .i_last_sample (i_last_sample),
    .empty         (empty),
    .pop           (pop),
    .o_out_red     (o_out_red),
    .o_out_green   (o_out_green),
    .o_out_blue    (o_out_blue),
    .o_out_alpha   (o_out_alpha)
);
`default_nettype wire
